[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types and tables for the source text tokenizer
// Token kinds, character codes, keyword table and the result record that
// travels from the scanner into the result queue.
// ----------------------------------------------------------------------------
package stt_pkg;

	// default settings for the top level parameters
	localparam int COUNT_BITS_DEF    = 16;
	localparam int KEYWORD_CHARS_DEF = 6;

	// result field widths
	localparam int KIND_W  = 6;
	localparam int FIELD_W = 16;

	// result queue depth
	localparam int QUEUE_DEPTH = 4;

	// token kinds
	localparam logic [KIND_W-1:0] K_DIV    = 6'd9;
	localparam logic [KIND_W-1:0] K_LT     = 6'd10;
	localparam logic [KIND_W-1:0] K_GT     = 6'd12;
	localparam logic [KIND_W-1:0] K_ASSIGN = 6'd14;
	localparam logic [KIND_W-1:0] K_BANG   = 6'd16;
	localparam logic [KIND_W-1:0] K_STRING = 6'd18;
	localparam logic [KIND_W-1:0] K_NUMBER = 6'd19;
	localparam logic [KIND_W-1:0] K_IDENT  = 6'd20;
	localparam logic [KIND_W-1:0] K_KW0    = 6'd21;
	localparam logic [KIND_W-1:0] K_ERROR  = 6'd33;

	localparam int NUM_KEYWORDS = 12;

	// character codes
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// one result record
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic               last;
	} token_t;

	// up to two results from one input transfer
	typedef struct packed {
		logic [1:0] cnt;
		token_t     r0;
		token_t     r1;
	} emit_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return c == CH_UNDER || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_op_char(input logic [7:0] c);
		return c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG;
	endfunction

	// {hit, kind} for single-character punctuation
	function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
		logic [KIND_W:0] r;
		case (c)
			CH_COMMA:  r = {1'b1, 6'd0};
			CH_LPAREN: r = {1'b1, 6'd1};
			CH_RPAREN: r = {1'b1, 6'd2};
			CH_LBRACE: r = {1'b1, 6'd3};
			CH_RBRACE: r = {1'b1, 6'd4};
			CH_PLUS:   r = {1'b1, 6'd5};
			CH_MINUS:  r = {1'b1, 6'd6};
			CH_STAR:   r = {1'b1, 6'd7};
			CH_SEMI:   r = {1'b1, 6'd8};
			default:   r = '0;
		endcase
		return r;
	endfunction

	// kind of a lone operator character
	function automatic logic [KIND_W-1:0] op_base(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_LT:   k = K_LT;
			CH_GT:   k = K_GT;
			CH_EQ:   k = K_ASSIGN;
			default: k = K_BANG;
		endcase
		return k;
	endfunction

	// keyword text, packed with the first letter in the most significant byte
	function automatic logic [63:0] kw_packed(input int k);
		logic [63:0] p;
		case (k)
			0:       p = 64'h0000_0000_0076_6172; // var
			1:       p = 64'h0000_0000_6675_6e63; // func
			2:       p = 64'h0000_0000_0000_6966; // if
			3:       p = 64'h0000_0000_656c_6966; // elif
			4:       p = 64'h0000_0000_656c_7365; // else
			5:       p = 64'h0000_0000_0066_6f72; // for
			6:       p = 64'h0000_0077_6869_6c65; // while
			7:       p = 64'h0000_0000_7472_7565; // true
			8:       p = 64'h0000_0066_616c_7365; // false
			9:       p = 64'h0000_0070_7269_6e74; // print
			10:      p = 64'h0000_0063_6c61_7373; // class
			11:      p = 64'h0000_7265_7475_726e; // return
			default: p = '0;
		endcase
		return p;
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] n;
		case (k)
			0, 5:             n = 4'd3;
			1, 3, 4, 7:       n = 4'd4;
			2:                n = 4'd2;
			6, 8, 9, 10:      n = 4'd5;
			11:               n = 4'd6;
			default:          n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

[rtl/stt_scan.sv]
// ----------------------------------------------------------------------------
// stt_scan: front end scanner
// Classifies one source byte per transfer, keeps the pending token and
// produces up to two result records for the result queue.
// ----------------------------------------------------------------------------
module stt_scan #(
	parameter int COUNT_BITS    = stt_pkg::COUNT_BITS_DEF,
	parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_code,
	input  logic           end_of_text,
	output stt_pkg::emit_t emit
);
	import stt_pkg::*;

	localparam int WIN_W = KEYWORD_CHARS * 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [6:0] {
		M_IDLE    = 7'b0000001,
		M_OP      = 7'b0000010,
		M_SLASH   = 7'b0000100,
		M_COMMENT = 7'b0001000,
		M_STRING  = 7'b0010000,
		M_NUMBER  = 7'b0100000,
		M_IDENT   = 7'b1000000
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [COUNT_BITS-1:0]  line_q, line_d;
	logic [COUNT_BITS-1:0]  pos_q, pos_d;
	logic [COUNT_BITS-1:0]  tstart_q, tstart_d;
	logic [COUNT_BITS-1:0]  tlen_q, tlen_d;
	logic [WIN_W-1:0]       win_q, win_d;

	logic [KIND_W-1:0]      ident_kind;
	logic                   kw_hit;
	logic                   flush_v;
	logic [KIND_W-1:0]      flush_kind;
	logic [COUNT_BITS-1:0]  flush_len;
	logic                   first_v, second_v;
	logic [KIND_W-1:0]      first_kind, second_kind;
	logic [COUNT_BITS-1:0]  first_len;
	logic                   do_flush, do_start;
	logic [KIND_W:0]        punct;
	token_t                 first_tok, second_tok;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
		return (x == COUNT_MAX) ? x : x + 1'b1;
	endfunction

	// keyword match over the window, each keyword compared on its own
	always_comb begin
		kw_hit     = 1'b0;
		ident_kind = K_IDENT;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			if (!kw_hit && tlen_q == COUNT_BITS'(kw_len(k)) &&
			    int'(kw_len(k)) <= KEYWORD_CHARS && 64'(win_q) == kw_packed(k)) begin
				kw_hit     = 1'b1;
				ident_kind = KIND_W'(int'(K_KW0) + k);
			end
		end
	end

	// token that a flush of the pending mode gives
	always_comb begin
		flush_v    = 1'b1;
		flush_kind = K_IDENT;
		flush_len  = tlen_q;
		case (mode_q)
			M_OP: begin
				flush_kind = op_base(win_q[7:0]);
				flush_len  = COUNT_BITS'(1);
			end
			M_SLASH: begin
				flush_kind = K_DIV;
				flush_len  = COUNT_BITS'(1);
			end
			M_STRING: flush_kind = K_ERROR;
			M_NUMBER: flush_kind = K_NUMBER;
			M_IDENT:  flush_kind = ident_kind;
			default:  flush_v = 1'b0;
		endcase
	end

	assign punct = punct_lookup(char_code);

	// next state and results of one transfer
	always_comb begin
		mode_d      = mode_q;
		line_d      = line_q;
		pos_d       = pos_q;
		tstart_d    = tstart_q;
		tlen_d      = tlen_q;
		win_d       = win_q;
		do_flush    = 1'b0;
		do_start    = 1'b0;
		first_v     = 1'b0;
		first_kind  = flush_kind;
		first_len   = flush_len;
		second_v    = 1'b0;
		second_kind = punct[KIND_W-1:0];

		if (end_of_text) begin
			do_flush = 1'b1;
			mode_d   = M_IDLE;
		end else begin
			pos_d = sat_inc(pos_q);
			case (mode_q)
				M_OP: begin
					if (char_code == CH_EQ) begin
						first_v    = 1'b1;
						first_kind = KIND_W'(op_base(win_q[7:0]) + 6'd1);
						first_len  = COUNT_BITS'(2);
						mode_d     = M_IDLE;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_SLASH: begin
					if (char_code == CH_SLASH) begin
						mode_d = M_COMMENT;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_COMMENT: begin
					if (char_code == CH_NL) begin
						do_start = 1'b1;
					end
				end
				M_STRING: begin
					if (char_code == CH_QUOTE) begin
						first_v    = 1'b1;
						first_kind = K_STRING;
						first_len  = tlen_q;
						mode_d     = M_IDLE;
					end else if (is_alpha(char_code)) begin
						tlen_d = sat_inc(tlen_q);
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(char_code)) begin
						tlen_d = sat_inc(tlen_q);
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(char_code)) begin
						tlen_d = sat_inc(tlen_q);
						win_d  = {win_q[WIN_W-9:0], char_code};
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
		end

		if (do_flush && flush_v) begin
			first_v = 1'b1;
		end

		// scan the byte as the start of a new token
		if (do_start) begin
			mode_d = M_IDLE;
			if (punct[KIND_W]) begin
				second_v = 1'b1;
			end else begin
				tstart_d = pos_q;
				tlen_d   = COUNT_BITS'(1);
				if (char_code == CH_SLASH) begin
					mode_d = M_SLASH;
				end else if (is_op_char(char_code)) begin
					mode_d = M_OP;
					win_d  = WIN_W'(char_code);
				end else if (char_code == CH_QUOTE) begin
					mode_d   = M_STRING;
					tstart_d = sat_inc(pos_q);
					tlen_d   = '0;
				end else if (is_ident_start(char_code)) begin
					mode_d = M_IDENT;
					win_d  = WIN_W'(char_code);
				end else if (is_digit(char_code)) begin
					mode_d = M_NUMBER;
				end else if (char_code == CH_NL) begin
					line_d = sat_inc(line_q);
				end
			end
		end
	end

	// result records
	always_comb begin
		first_tok.kind    = first_kind;
		first_tok.line    = FIELD_W'(line_q);
		first_tok.start   = FIELD_W'(tstart_q);
		first_tok.length  = FIELD_W'(first_len);
		first_tok.last    = !second_v;
		second_tok.kind   = second_kind;
		second_tok.line   = FIELD_W'(line_q);
		second_tok.start  = FIELD_W'(pos_q);
		second_tok.length = FIELD_W'(1);
		second_tok.last   = 1'b1;

		emit.r0  = first_v ? first_tok : second_tok;
		emit.r1  = second_tok;
		emit.cnt = accept ? (2'(first_v) + 2'(second_v)) : 2'd0;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			line_q   <= '0;
			pos_q    <= '0;
			tstart_q <= '0;
			tlen_q   <= '0;
			win_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			pos_q    <= pos_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
			win_q    <= win_d;
		end
	end

	// end of text always leaves the scanner with nothing pending
	assert property (@(posedge clk) disable iff (!arst_n)
		arst_n && accept && end_of_text |=> mode_q == M_IDLE && $stable(pos_q))
	else $error("scanner not idle after end of text");

	// each source byte advances the position by one until it saturates
	assert property (@(posedge clk) disable iff (!arst_n)
		arst_n && accept && !end_of_text && pos_q != COUNT_MAX
		|=> pos_q == COUNT_BITS'($past(pos_q) + 1'b1))
	else $error("byte position did not advance");

	// only the final record of a transfer carries the last mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit.cnt == 2'd2 |-> emit.r1.last && !emit.r0.last) and
		(emit.cnt == 2'd1 |-> emit.r0.last))
	else $error("last mark misplaced");

endmodule

[rtl/stt_queue.sv]
// ----------------------------------------------------------------------------
// stt_queue: result queue and output stage
// Takes up to two result records per cycle from the scanner and hands them
// out one at a time, oldest first.
// ----------------------------------------------------------------------------
module stt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::emit_t  emit,
	input  logic            rd,
	output stt_pkg::token_t head,
	output logic            empty,
	output logic            room2
);
	import stt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         wr_n;
	logic               pop_ok;

	assign wr_n   = emit.cnt;
	assign empty  = (count_q == '0);
	assign room2  = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign pop_ok = rd && !empty;
	assign head   = mem[rptr_q];

	// storage writes, one or two per cycle
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem[wptr_q] <= emit.r0;
		end
		if (wr_n == 2'd2) begin
			mem[PTR_W'(wptr_q + 1'b1)] <= emit.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= PTR_W'(wptr_q + PTR_W'(wr_n));
			rptr_q  <= PTR_W'(rptr_q + PTR_W'(pop_ok));
			count_q <= CNT_W'(count_q + CNT_W'(wr_n) - CNT_W'(pop_ok));
		end
	end

	// fill count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
	else $error("result queue overflow");

	// fill count follows the writes and reads of the previous cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		arst_n |=> count_q == CNT_W'($past(count_q) + CNT_W'($past(wr_n))
			- CNT_W'($past(pop_ok))))
	else $error("result queue count mismatch");

	// pointer distance agrees with the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(wptr_q - rptr_q) == PTR_W'(count_q))
	else $error("result queue pointers out of step");

endmodule

[rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming tokenizer for source text
// Turns a byte stream into tokens with kind, line, start offset and length.
// ----------------------------------------------------------------------------
// The block takes one source byte (or an end-of-text mark) per cycle while full
// is low and scans it in the same cycle; each transfer yields zero, one or two
// tokens, which go into a four-entry result queue and leave at one per cycle
// through the empty/pop side. full rises when the queue has fewer than two
// free entries, so the sustained input rate is one byte per cycle as long as
// tokens are popped at least as fast as they are made; two-token bytes and a
// slow reader are what hold the input back. With the queue empty, a result
// appears on the output ports in the cycle after the byte that caused it was taken.
module source_text_tokenizer #(
	parameter int COUNT_BITS    = stt_pkg::COUNT_BITS_DEF,
	parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  token_kind,
	output logic [15:0] line_number,
	output logic [15:0] start_offset,
	output logic [15:0] text_length,
	output logic        last_in_run
);
	import stt_pkg::*;

	emit_t  emit;
	token_t head;
	logic   room2;
	logic   accept;

	// input transfer
	assign full   = !room2;
	assign accept = push && room2;

	// front end scanner
	stt_scan #(
		.COUNT_BITS    (COUNT_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.emit        (emit)
	);

	// result queue
	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.emit   (emit),
		.rd     (pop),
		.head   (head),
		.empty  (empty),
		.room2  (room2)
	);

	// result ports
	assign token_kind   = head.kind;
	assign line_number  = head.line;
	assign start_offset = head.start;
	assign text_length  = head.length;
	assign last_in_run  = head.last;

endmodule
